// ----- hw/rtl/assert_macros.svh -----
// assertion helpers, sampled on clock; the implication checks are disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// check that also holds on the cycle right after reset
`define ASSERT_AFTER_RESET(lbl, cons) \
   lbl: assert property (@(posedge clock) $past(reset) |-> (cons)) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/ctracpkm_pkg.sv -----
package ctracpkm_pkg;

   localparam int BlkW = 128;

   localparam logic [2:0] REG_KEY0 = 3'd0;
   localparam logic [2:0] REG_KEY1 = 3'd1;
   localparam logic [2:0] REG_KEY2 = 3'd2;
   localparam logic [2:0] REG_KEY3 = 3'd3;
   localparam logic [2:0] REG_IV   = 3'd4;
   localparam logic [2:0] REG_SECT = 3'd5;

   localparam logic [BlkW-1:0] D1_CONST = 128'h808182838485868788898a8b8c8d8e8f;
   localparam logic [BlkW-1:0] D2_CONST = 128'h909192939495969798999a9b9c9d9e9f;

   typedef enum logic [2:0] {
      U_HOLD,
      U_LOAD,
      U_SUB,
      U_LIN,
      U_XOR
   } unit_op_type;

   typedef struct packed {
      unit_op_type     op;
      logic [BlkW-1:0] opnd;
   } unit_ctl_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_PREP,
      S_KINIT,
      S_KINIT2,
      S_KCONST,
      S_KSUB,
      S_KLIN,
      S_KMIX,
      S_KSTORE,
      S_ESUB,
      S_ELIN,
      S_EFIN,
      S_EDONE
   } st_type;

   typedef enum logic [1:0] {
      PH_D1,
      PH_D2,
      PH_CTR
   } ph_type;

   localparam logic [7:0] SBOX [256] = '{
      252,238,221, 17,207,110, 49, 22,251,196,250,218, 35,197,  4, 77,
      233,119,240,219,147, 46,153,186, 23, 54,241,187, 20,205, 95,193,
      249, 24,101, 90,226, 92,239, 33,129, 28, 60, 66,139,  1,142, 79,
        5,132,  2,174,227,106,143,160,  6, 11,237,152,127,212,211, 31,
      235, 52, 44, 81,234,200, 72,171,242, 42,104,162,253, 58,206,204,
      181,112, 14, 86,  8, 12,118, 18,191,114, 19, 71,156,183, 93,135,
       21,161,150, 41, 16,123,154,199,243,145,120,111,157,158,178,177,
       50,117, 25, 61,255, 53,138,126,109, 84,198,128,195,189, 13, 87,
      223,245, 36,169, 62,168, 67,201,215,121,214,246,124, 34,185,  3,
      224, 15,236,222,122,148,176,188,220,232, 40, 80, 78, 51, 10, 74,
      167,151, 96,115, 30,  0, 98, 68, 26,184, 56,130,100,159, 38, 65,
      173, 69, 70,146, 39, 94, 85, 47,140,163,165,125,105,213,149, 59,
        7, 88,179, 64,134,172, 29,247, 48, 55,107,228,136,217,231,137,
      225, 27,131, 73, 76, 63,248,254,141, 83,170,144,202,216,133, 97,
       32,113,103,164, 45, 43,  9, 91,203,155, 37,208,190,229,108, 82,
       89,166,116,210,230,244,180,192,209,102,175,194, 57, 75, 99,182
   };

   localparam logic [7:0] LCOEF [16] = '{
      148, 32, 133, 16, 194, 192, 1, 251, 1, 192, 194, 16, 133, 32, 148, 1
   };

   function automatic logic [7:0] gf_mul(input logic [7:0] a_in, input logic [7:0] b);
      logic [7:0] a;
      logic [7:0] r;
      a = a_in;
      r = '0;
      for (int n = 0; n < 8; n++) begin
         if (b[n]) r = r ^ a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'hC3 : 8'h00);
      end
      return r;
   endfunction

   // one step of the linear layer, byte 0 in the top bits
   function automatic logic [BlkW-1:0] l_step(input logic [BlkW-1:0] blk);
      logic [7:0] t;
      t = '0;
      for (int i = 0; i < 16; i++) begin
         t = t ^ gf_mul(LCOEF[i], blk[BlkW-1-8*i -: 8]);
      end
      return {t, blk[BlkW-1:8]};
   endfunction

   function automatic logic [BlkW-1:0] s_layer(input logic [BlkW-1:0] blk);
      logic [BlkW-1:0] o;
      for (int i = 0; i < 16; i++) begin
         o[8*i +: 8] = SBOX[blk[8*i +: 8]];
      end
      return o;
   endfunction

   // key schedule round constant source: byte 15 holds the round number
   function automatic logic [BlkW-1:0] rc_seed(input logic [4:0] idx);
      return {120'b0, (8'({3'b000, idx}) + 8'd1)};
   endfunction

endpackage

// ----- hw/rtl/ctracpkm_unit.sv -----
module ctracpkm_unit (
   input  logic                      clock,
   input  ctracpkm_pkg::unit_ctl_type ctl,
   output logic [127:0]              wk
);
   import ctracpkm_pkg::*;

   logic [BlkW-1:0] wk_ff;
   logic [BlkW-1:0] wk_in;

   always_comb begin
      unique case (ctl.op)
         U_HOLD:  wk_in = wk_ff;
         U_LOAD:  wk_in = ctl.opnd;
         U_SUB:   wk_in = s_layer(wk_ff ^ ctl.opnd);
         U_LIN:   wk_in = l_step(wk_ff);
         U_XOR:   wk_in = wk_ff ^ ctl.opnd;
         default: wk_in = wk_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      wk_ff <= wk_in;
   end

   assign wk = wk_ff;

endmodule

// ----- hw/rtl/ctr_acpkm_block_cipher_mode.sv -----
// Kuznyechik CTR-ACPKM: each request block is XORed with the encryption of a
// 128-bit counter (IV || 0 at message start, +1 per block); bytes past the
// valid count come out zero. One shared round unit does all the work: an
// S layer pass works on the whole block at once and the linear layer on one
// byte per cycle. Round keys are kept and re-expanded only after a message
// start or a section rekey; expansion runs 32 Feistel rounds. Requests are
// taken one at a time; a response waits in an output register.
module ctr_acpkm_block_cipher_mode (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,   // in_hi, in_lo, valid_bytes, zero pad
   input  logic         req_tuser,   // start_message
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // out_hi, out_lo, out_valid_bytes, zero pad
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_wdata
);
   import ctracpkm_pkg::*;

   localparam logic [3:0] RK_LAST = 4'd9;

   logic [63:0]     cfg_key_ff [4];
   logic [63:0]     cfg_iv_ff;
   logic [15:0]     cfg_sect_ff;

   st_type          st_ff, st_in;
   ph_type          ph_ff, ph_in;
   logic [BlkW-1:0] key_hi_ff, key_hi_in;
   logic [BlkW-1:0] key_lo_ff, key_lo_in;
   logic [BlkW-1:0] ctr_ff, ctr_in;
   logic [15:0]     sect_ff, sect_in;
   logic            rk_ok_ff, rk_ok_in;
   logic [4:0]      idx_ff, idx_in;
   logic [3:0]      cnt_ff, cnt_in;
   logic [3:0]      rnd_ff, rnd_in;
   logic [BlkW-1:0] dat_ff, dat_in;
   logic [4:0]      nv_ff, nv_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [135:0]    rsp_data_ff, rsp_data_in;

   logic [BlkW-1:0] rk_ff [10];
   logic            rk_we;
   logic [3:0]      rk_wa;
   logic [BlkW-1:0] rk_wd;

   unit_ctl_type    ctl;
   logic [BlkW-1:0] wk;
   logic [15:0]     sec_eff;
   logic [BlkW-1:0] res;
   logic [4:0]      nv_req;
   logic [BlkW-1:0] mix;

   ctracpkm_unit u_unit (
      .clock (clock),
      .ctl   (ctl),
      .wk    (wk)
   );

   assign sec_eff = (cfg_sect_ff == 16'd0) ? 16'd1 : cfg_sect_ff;
   assign nv_req  = (req_tdata[132:128] > 5'd16) ? 5'd16 : req_tdata[132:128];
   assign mix     = wk ^ key_lo_ff;

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         res[BlkW-1-8*i -: 8] = (5'(i) < nv_ff) ? (dat_ff[BlkW-1-8*i -: 8] ^
                                                  wk[BlkW-1-8*i -: 8]) : 8'h00;
      end
   end

   always_comb begin
      st_in        = st_ff;
      ph_in        = ph_ff;
      key_hi_in    = key_hi_ff;
      key_lo_in    = key_lo_ff;
      ctr_in       = ctr_ff;
      sect_in      = sect_ff;
      rk_ok_in     = rk_ok_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      rnd_in       = rnd_ff;
      dat_in       = dat_ff;
      nv_in        = nv_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rk_we        = 1'b0;
      rk_wa        = '0;
      rk_wd        = '0;
      ctl.op       = U_HOLD;
      ctl.opnd     = '0;

      unique case (st_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               dat_in = {req_tdata[63:0], req_tdata[127:64]};
               nv_in  = nv_req;
               if (req_tuser) begin
                  key_hi_in = {cfg_key_ff[0], cfg_key_ff[1]};
                  key_lo_in = {cfg_key_ff[2], cfg_key_ff[3]};
                  ctr_in    = {cfg_iv_ff, 64'd0};
                  sect_in   = '0;
                  rk_ok_in  = 1'b0;
               end
               st_in = S_CHECK;
            end
         end
         S_CHECK: begin
            ph_in = (sect_ff >= sec_eff) ? PH_D1 : PH_CTR;
            st_in = S_PREP;
         end
         S_PREP: begin
            if (!rk_ok_ff) begin
               st_in = S_KINIT;
            end else begin
               ctl.op = U_LOAD;
               unique case (ph_ff)
                  PH_D1:   ctl.opnd = D1_CONST;
                  PH_D2:   ctl.opnd = D2_CONST;
                  PH_CTR:  ctl.opnd = ctr_ff;
                  default: ctl.opnd = ctr_ff;
               endcase
               rnd_in = '0;
               st_in  = S_ESUB;
            end
         end
         S_KINIT: begin
            rk_we = 1'b1;
            rk_wa = 4'd0;
            rk_wd = key_hi_ff;
            st_in = S_KINIT2;
         end
         S_KINIT2: begin
            rk_we    = 1'b1;
            rk_wa    = 4'd1;
            rk_wd    = key_lo_ff;
            idx_in   = '0;
            ctl.op   = U_LOAD;
            ctl.opnd = rc_seed(5'd0);
            cnt_in   = '0;
            st_in    = S_KCONST;
         end
         S_KCONST: begin
            ctl.op = U_LIN;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) st_in = S_KSUB;
         end
         S_KSUB: begin
            ctl.op   = U_SUB;
            ctl.opnd = key_hi_ff;
            cnt_in   = '0;
            st_in    = S_KLIN;
         end
         S_KLIN: begin
            ctl.op = U_LIN;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) st_in = S_KMIX;
         end
         S_KMIX: begin
            key_hi_in = mix;
            key_lo_in = key_hi_ff;
            if (idx_ff[2:0] == 3'b111) begin
               rk_we = 1'b1;
               rk_wa = {1'b0, idx_ff[4:3], 1'b0} + 4'd2;
               rk_wd = mix;
               st_in = S_KSTORE;
            end else begin
               idx_in   = idx_ff + 5'd1;
               ctl.op   = U_LOAD;
               ctl.opnd = rc_seed(idx_ff + 5'd1);
               cnt_in   = '0;
               st_in    = S_KCONST;
            end
         end
         S_KSTORE: begin
            rk_we = 1'b1;
            rk_wa = {1'b0, idx_ff[4:3], 1'b0} + 4'd3;
            rk_wd = key_lo_ff;
            if (idx_ff == 5'd31) begin
               rk_ok_in = 1'b1;
               st_in    = S_PREP;
            end else begin
               idx_in   = idx_ff + 5'd1;
               ctl.op   = U_LOAD;
               ctl.opnd = rc_seed(idx_ff + 5'd1);
               cnt_in   = '0;
               st_in    = S_KCONST;
            end
         end
         S_ESUB: begin
            ctl.op   = U_SUB;
            ctl.opnd = rk_ff[rnd_ff];
            cnt_in   = '0;
            st_in    = S_ELIN;
         end
         S_ELIN: begin
            ctl.op = U_LIN;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               if (rnd_ff == 4'd8) begin
                  st_in = S_EFIN;
               end else begin
                  rnd_in = rnd_ff + 4'd1;
                  st_in  = S_ESUB;
               end
            end
         end
         S_EFIN: begin
            ctl.op   = U_XOR;
            ctl.opnd = rk_ff[RK_LAST];
            st_in    = S_EDONE;
         end
         S_EDONE: begin
            unique case (ph_ff)
               PH_D1: begin
                  key_hi_in = wk;
                  ph_in     = PH_D2;
                  st_in     = S_PREP;
               end
               PH_D2: begin
                  key_lo_in = wk;
                  rk_ok_in  = 1'b0;
                  sect_in   = '0;
                  ph_in     = PH_CTR;
                  st_in     = S_PREP;
               end
               default: begin
                  if (!rsp_valid_ff || rsp_tready) begin
                     rsp_data_in  = {3'b000, nv_ff, res[63:0], res[127:64]};
                     rsp_valid_in = 1'b1;
                     ctr_in       = ctr_ff + 128'd1;
                     sect_in      = sect_ff + 16'd1;
                     st_in        = S_IDLE;
                  end
               end
            endcase
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         ph_ff        <= PH_CTR;
         key_hi_ff    <= '0;
         key_lo_ff    <= '0;
         ctr_ff       <= '0;
         sect_ff      <= '0;
         rk_ok_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_key_ff   <= '{default: '0};
         cfg_iv_ff    <= '0;
         cfg_sect_ff  <= 16'd2;
      end else begin
         st_ff        <= st_in;
         ph_ff        <= ph_in;
         key_hi_ff    <= key_hi_in;
         key_lo_ff    <= key_lo_in;
         ctr_ff       <= ctr_in;
         sect_ff      <= sect_in;
         rk_ok_ff     <= rk_ok_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               REG_KEY0: cfg_key_ff[0] <= csr_wdata;
               REG_KEY1: cfg_key_ff[1] <= csr_wdata;
               REG_KEY2: cfg_key_ff[2] <= csr_wdata;
               REG_KEY3: cfg_key_ff[3] <= csr_wdata;
               REG_IV:   cfg_iv_ff     <= csr_wdata;
               REG_SECT: cfg_sect_ff   <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      rnd_ff      <= rnd_in;
      dat_ff      <= dat_in;
      nv_ff       <= nv_in;
      rsp_data_ff <= rsp_data_in;
      if (rk_we) rk_ff[rk_wa] <= rk_wd;
   end

   assign req_tready = (st_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- hw/rtl/ctracpkm_chk.sv -----
`include "assert_macros.svh"

module ctracpkm_chk (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [135:0] rsp_tdata
);

   `ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `ASSERT_NEXT(a_busy_after_req, req_tvalid && req_tready, !req_tready)
   `ASSERT_IMPL(a_count_range, rsp_tvalid, rsp_tdata[132:128] <= 5'd16 && rsp_tdata[135:133] == 3'b000)
   `ASSERT_AFTER_RESET(a_rsp_clear, !rsp_tvalid && req_tready)

endmodule

bind ctr_acpkm_block_cipher_mode ctracpkm_chk u_chk (.*);

// ----- tb/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ctracpkm_pkg::*;

   typedef struct packed {
      logic        start;
      logic [63:0] hi;
      logic [63:0] lo;
      logic [4:0]  nbytes;
   } block_req_type;

   typedef struct packed {
      logic [63:0] hi;
      logic [63:0] lo;
      logic [4:0]  nbytes;
   } block_rsp_type;

   localparam logic [7:0] PI_TBL [256] = '{
      252,238,221, 17,207,110, 49, 22,251,196,250,218, 35,197,  4, 77,
      233,119,240,219,147, 46,153,186, 23, 54,241,187, 20,205, 95,193,
      249, 24,101, 90,226, 92,239, 33,129, 28, 60, 66,139,  1,142, 79,
        5,132,  2,174,227,106,143,160,  6, 11,237,152,127,212,211, 31,
      235, 52, 44, 81,234,200, 72,171,242, 42,104,162,253, 58,206,204,
      181,112, 14, 86,  8, 12,118, 18,191,114, 19, 71,156,183, 93,135,
       21,161,150, 41, 16,123,154,199,243,145,120,111,157,158,178,177,
       50,117, 25, 61,255, 53,138,126,109, 84,198,128,195,189, 13, 87,
      223,245, 36,169, 62,168, 67,201,215,121,214,246,124, 34,185,  3,
      224, 15,236,222,122,148,176,188,220,232, 40, 80, 78, 51, 10, 74,
      167,151, 96,115, 30,  0, 98, 68, 26,184, 56,130,100,159, 38, 65,
      173, 69, 70,146, 39, 94, 85, 47,140,163,165,125,105,213,149, 59,
        7, 88,179, 64,134,172, 29,247, 48, 55,107,228,136,217,231,137,
      225, 27,131, 73, 76, 63,248,254,141, 83,170,144,202,216,133, 97,
       32,113,103,164, 45, 43,  9, 91,203,155, 37,208,190,229,108, 82,
       89,166,116,210,230,244,180,192,209,102,175,194, 57, 75, 99,182
   };
   localparam logic [7:0] MIX_COEF [16] = '{
      148, 32, 133, 16, 194, 192, 1, 251, 1, 192, 194, 16, 133, 32, 148, 1
   };

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [135:0] req_tdata;
   logic         req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [135:0] rsp_tdata;
   logic         csr_wr_en;
   logic [2:0]   csr_index;
   logic [63:0]  csr_wdata;

   block_req_type pending_blocks[$];
   block_rsp_type expected_blocks[$];
   logic [63:0]  csr_shadow [6];
   logic [255:0] cipher_key;
   logic [127:0] ctr_value;
   logic [15:0]  section_count;
   logic [127:0] round_keys [10];
   int           mismatches;
   bit           calm;
   bit           send_hold;
   bit           stall_go;
   int           stall_left;

   ctr_acpkm_block_cipher_mode dut (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic logic [7:0] gf_times(input logic [7:0] a_in, input logic [7:0] b);
      logic [7:0] a;
      logic [7:0] r;
      a = a_in;
      r = '0;
      for (int n = 0; n < 8; n++) begin
         if (b[n]) r ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'hC3 : 8'h00);
      end
      return r;
   endfunction

   function automatic logic [127:0] mix_layer(input logic [127:0] x_in);
      logic [127:0] x;
      logic [7:0]   t;
      x = x_in;
      for (int r = 0; r < 16; r++) begin
         t = '0;
         for (int i = 0; i < 16; i++) t ^= gf_times(MIX_COEF[i], x[127-8*i -: 8]);
         x = {t, x[127:8]};
      end
      return x;
   endfunction

   function automatic logic [127:0] round_fn(input logic [127:0] x, input logic [127:0] k);
      logic [127:0] y;
      y = x ^ k;
      for (int i = 0; i < 16; i++) y[8*i +: 8] = PI_TBL[y[8*i +: 8]];
      return mix_layer(y);
   endfunction

   function automatic void schedule_keys(input logic [255:0] k);
      logic [127:0] a1;
      logic [127:0] a0;
      logic [127:0] t;
      a1 = k[255:128];
      a0 = k[127:0];
      round_keys[0] = a1;
      round_keys[1] = a0;
      for (int i = 0; i < 4; i++) begin
         for (int j = 1; j <= 8; j++) begin
            t = round_fn(a1, mix_layer(128'(8 * i + j))) ^ a0;
            a0 = a1;
            a1 = t;
         end
         round_keys[2*i+2] = a1;
         round_keys[2*i+3] = a0;
      end
   endfunction

   function automatic logic [127:0] cipher_block(input logic [127:0] b_in);
      logic [127:0] b;
      b = b_in;
      for (int r = 0; r < 9; r++) b = round_fn(b, round_keys[r]);
      return b ^ round_keys[9];
   endfunction

   function automatic block_rsp_type ctr_keystream_xor(input block_req_type rq);
      logic [15:0]  sect;
      logic [127:0] ks;
      logic [127:0] d;
      logic [4:0]   n;
      block_rsp_type rs;
      if (rq.start) begin
         cipher_key = {csr_shadow[0], csr_shadow[1], csr_shadow[2], csr_shadow[3]};
         ctr_value = {csr_shadow[4], 64'd0};
         section_count = '0;
      end
      sect = csr_shadow[5][15:0];
      if (sect == 0) sect = 1;
      if (section_count >= sect) begin
         schedule_keys(cipher_key);
         cipher_key = {cipher_block(128'h808182838485868788898a8b8c8d8e8f),
                       cipher_block(128'h909192939495969798999a9b9c9d9e9f)};
         section_count = '0;
      end
      schedule_keys(cipher_key);
      ks = cipher_block(ctr_value);
      ctr_value = ctr_value + 128'd1;
      section_count = section_count + 16'd1;
      n = (rq.nbytes > 16) ? 5'd16 : rq.nbytes;
      d = {rq.hi, rq.lo} ^ ks;
      for (int i = 0; i < 16; i++) if (i >= n) d[127-8*i -: 8] = 8'h00;
      rs.hi = d[127:64];
      rs.lo = d[63:0];
      rs.nbytes = n;
      return rs;
   endfunction

   // request driver
   always @(posedge clock) begin
      block_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_blocks.push_back(ctr_keystream_xor({req_tuser, req_tdata[63:0],
               req_tdata[127:64], req_tdata[132:128]}));
         if (!req_tvalid || req_tready) begin
            if (pending_blocks.size() > 0 && !send_hold &&
                (calm || $urandom_range(99) >= 32)) begin
               nxt = pending_blocks.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= nxt.start;
               req_tdata <= {3'b000, nxt.nbytes, nxt.lo, nxt.hi};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      block_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_blocks.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %h", rsp_tdata);
            end else begin
               want = expected_blocks.pop_front();
               if (rsp_tdata[63:0] !== want.hi || rsp_tdata[127:64] !== want.lo ||
                   rsp_tdata[132:128] !== want.nbytes) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp hi %h lo %h n %0d, got hi %h lo %h n %0d",
                        want.hi, want.lo, want.nbytes, rsp_tdata[63:0],
                        rsp_tdata[127:64], rsp_tdata[132:128]);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (stall_go) begin
            stall_go <= 1'b0;
            stall_left <= 3000;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || $urandom_range(99) >= 32;
         end
      end
   end

   task automatic wait_idle();
      while (pending_blocks.size() > 0 || expected_blocks.size() > 0 || req_tvalid)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      csr_shadow[idx] = val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic load_all(input logic [255:0] k, input logic [63:0] iv,
                           input logic [63:0] sect);
      write_reg(REG_KEY0, k[255:192]);
      write_reg(REG_KEY1, k[191:128]);
      write_reg(REG_KEY2, k[127:64]);
      write_reg(REG_KEY3, k[63:0]);
      write_reg(REG_IV, iv);
      write_reg(REG_SECT, sect);
   endtask

   task automatic add_block(input logic st, input logic [4:0] n);
      block_req_type b;
      b.start = st;
      b.hi = {$urandom, $urandom};
      b.lo = {$urandom, $urandom};
      b.nbytes = n;
      pending_blocks.push_back(b);
   endtask

   task automatic add_fixed(input logic st, input logic [63:0] h, input logic [63:0] l,
                            input logic [4:0] n);
      pending_blocks.push_back('{st, h, l, n});
   endtask

   task automatic add_messages(input int count);
      int len;
      int k;
      k = 0;
      while (k < count) begin
         if ($urandom_range(9) == 0) begin
            // stray block or broken message
            add_block(1'($urandom_range(1)), 5'($urandom_range(31)));
            k++;
         end else begin
            len = $urandom_range(1, 12);
            for (int j = 0; j < len; j++) begin
               add_block(j == 0, (j == len - 1 && $urandom_range(2) != 0) ?
                  5'($urandom_range(31)) : 5'd16);
            end
            k += len;
         end
      end
   endtask

   function automatic logic [255:0] rand_key();
      return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom};
   endfunction

   initial begin
      req_tvalid = 1'b0;
      req_tuser = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      mismatches = 0;
      calm = 1'b0;
      send_hold = 1'b0;
      stall_go = 1'b0;
      stall_left = 0;
      cipher_key = '0;
      ctr_value = '0;
      section_count = '0;
      for (int i = 0; i < 5; i++) csr_shadow[i] = '0;
      csr_shadow[5] = 64'd2;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      load_all(256'h8899aabbccddeeff0011223344556677fedcba98765432100123456789abcdef,
               64'h1234567890abcef0, 64'd2);
      // zero state before any message start
      add_fixed(1'b0, 64'h0, 64'h0, 5'd16);
      add_fixed(1'b0, '1, '1, 5'd16);
      add_fixed(1'b1, '1, '1, 5'd16);
      add_fixed(1'b0, 64'h0, 64'h0, 5'd16);
      add_fixed(1'b0, 64'h1122334455667700, 64'hffeeddccbbaa9988, 5'd16);
      add_fixed(1'b0, '1, '1, 5'd0);
      add_fixed(1'b0, '1, '1, 5'd1);
      add_fixed(1'b0, '1, '1, 5'd15);
      add_fixed(1'b0, '1, '1, 5'd17);
      add_fixed(1'b0, '1, '1, 5'd31);
      add_fixed(1'b1, 64'h0, '1, 5'd8);
      add_fixed(1'b0, '1, 64'h0, 5'd16);
      wait_idle();

      // section length zero and one, extreme key and iv
      load_all('1, '1, 64'd0);
      add_block(1'b1, 5'd16);
      add_block(1'b0, 5'd16);
      add_block(1'b0, 5'd16);
      wait_idle();
      load_all('0, '0, 64'd1);
      add_block(1'b1, 5'd16);
      add_block(1'b0, 5'd9);
      add_block(1'b0, 5'd16);
      wait_idle();

      // section lowered in the middle of a message
      load_all(rand_key(), {$urandom, $urandom}, 64'hffff);
      for (int j = 0; j < 6; j++) add_block(j == 0, 5'd16);
      wait_idle();
      write_reg(REG_SECT, 64'd2);
      for (int j = 0; j < 4; j++) add_block(1'b0, 5'd16);
      wait_idle();

      for (int ph = 0; ph < 8; ph++) begin
         load_all(rand_key(), {$urandom, $urandom}, 64'($urandom_range(3, 20)));
         calm = (ph == 2);
         if (ph == 4) begin
            add_messages(40);
            stall_go = 1'b1;
            add_messages(40);
         end else if (ph == 6) begin
            add_messages(40);
            wait (pending_blocks.size() < 20);
            send_hold = 1'b1;
            wait (expected_blocks.size() == 0 && !req_tvalid);
            send_hold = 1'b0;
            add_messages(40);
         end else begin
            add_messages(85);
         end
         wait_idle();
      end
      calm = 1'b0;

      wait_idle();
      repeat (300) @(posedge clock);
      if (mismatches == 0 && expected_blocks.size() == 0) begin
         $display("ctr_acpkm_block_cipher_mode verification clean");
      end else begin
         $display("ctr_acpkm_block_cipher_mode verification failed");
      end
      $finish;
   end

   initial begin
      #200ms;
      $display("ctr_acpkm_block_cipher_mode verification failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/ctracpkm_pkg.sv
hw/rtl/ctracpkm_unit.sv
hw/rtl/ctr_acpkm_block_cipher_mode.sv
hw/rtl/ctracpkm_chk.sv
tb/tb.sv
